// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check
`define RSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle check
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// RSI package
// Widths, constants and item types shared by the RSI unit and its divider.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int PRICE_W         = 32;
  localparam int PRICE_FRAC_BITS = 16;
  localparam int GUARD_BITS      = 16;
  localparam int AVG_W           = PRICE_W + GUARD_BITS;
  localparam int PERIOD_W        = 8;
  localparam int CNT_W           = 8;
  localparam int MAX_PERIOD      = 255;
  localparam int PERIOD_RESET    = 14;
  localparam int RSI_W           = 23;
  localparam int RSI_SCALE       = 100;
  localparam int RSI_SCALE_W     = 7;

  localparam int PROD_W     = AVG_W + PERIOD_W;
  localparam int DIV_NUM_W  = PROD_W + 1;
  localparam int DIV_DEN_W  = AVG_W + 1;
  localparam int STEP_W     = $clog2(DIV_NUM_W + 1);
  localparam int RSI_MUL_W  = AVG_W + RSI_SCALE_W;
  localparam int RSI_NUM_W  = RSI_MUL_W + PRICE_FRAC_BITS;

  localparam logic [CNT_W-1:0]    SMOOTHING_MARK = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_CAP =
      PERIOD_W'((MAX_PERIOD > 255) ? 255 : MAX_PERIOD);
  localparam logic [RSI_W-1:0]    RSI_FULL = RSI_W'(RSI_SCALE << PRICE_FRAC_BITS);

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               new_series;
  } rsi_in_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic             no_loss;
  } rsi_out_t;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_DEN_W-1:0] rem;
    logic [STEP_W-1:0]    steps;
  } rsi_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rsi_div_sts_t;

endpackage

// File: rtl/rsi_div.sv
// ----------------------------------------------------------------------------
// RSI divider
// Restoring divider, one quotient bit per cycle, numerator taken MSB first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  rsi_pkg::rsi_div_req_t          req,
  output logic [rsi_pkg::AVG_W-1:0]      q,
  output rsi_pkg::rsi_div_sts_t          sts
);
  import rsi_pkg::*;

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [AVG_W-1:0]     q_r, q_nxt;
  logic [STEP_W-1:0]    cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 fits;

  assign rem_sh  = {rem_r, num_r[DIV_NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = req.rem;
      q_nxt    = '0;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_nxt = fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      q_nxt   = {q_r[AVG_W-2:0], fits};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign q        = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  `RSI_ASSERT(a_no_restart, start |-> !busy_r, "divider started while busy")
  `RSI_ASSERT(a_rem_bound, busy_r |-> (rem_r < den_r), "partial remainder not below divisor")
  `RSI_ASSERT(a_done_after_busy, done_r |-> $past(busy_r), "done without a division running")

endmodule

// File: rtl/relative_strength_index_unit.sv
// ----------------------------------------------------------------------------
// Relative strength index unit
// Wilder RSI over a price stream, all divisions on one shared serial divider.
// A smoothed price runs its gain and loss averages and then the RSI ratio
// through the divider; a zero loss average skips the ratio. No new item is taken
// until the result is in the output register. Series-start items and warm-up
// items but the last stay in idle. Synchronous reset: period 14, no series held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module relative_strength_index_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsi_pkg::rsi_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rsi_pkg::rsi_out_t               out_item,
  input  logic                            cfg_we,
  input  logic [rsi_pkg::PERIOD_W-1:0]    cfg_wdata
);
  import rsi_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD_G = 8'b0000_0010,
    S_WAIT_G = 8'b0000_0100,
    S_LOAD_L = 8'b0000_1000,
    S_WAIT_L = 8'b0001_0000,
    S_LOAD_R = 8'b0010_0000,
    S_WAIT_R = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic [PRICE_W-1:0]   last_price_r, last_price_nxt;
  logic [AVG_W-1:0]     gain_avg_r, gain_avg_nxt;
  logic [AVG_W-1:0]     loss_avg_r, loss_avg_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [PRICE_W-1:0]   gain_r, gain_nxt;
  logic [PRICE_W-1:0]   loss_r, loss_nxt;
  logic [PERIOD_W-1:0]  p_r, p_nxt;
  logic                 warm_end_r, warm_end_nxt;
  rsi_out_t             res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rsi_out_t             out_item_r, out_item_nxt;

  logic [PERIOD_W-1:0]  eff_period;
  logic [PRICE_W-1:0]   diff_gain, diff_loss;
  logic [CNT_W:0]       count_inc;
  logic [AVG_W-1:0]     sel_avg;
  logic [PRICE_W-1:0]   sel_x;
  logic [PERIOD_W-1:0]  p_less;
  logic [PROD_W-1:0]    prod;
  logic [DIV_NUM_W-1:0] num_avg;
  logic [RSI_MUL_W-1:0] gain_scaled;
  logic [RSI_NUM_W-1:0] rsi_num;

  logic                 div_start;
  rsi_div_req_t         div_req;
  logic [AVG_W-1:0]     div_q;
  rsi_div_sts_t         div_sts;

  rsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .q     (div_q),
    .sts   (div_sts)
  );

  always_comb begin
    if (period_r == '0) begin
      eff_period = PERIOD_W'(1);
    end else if (period_r > PERIOD_CAP) begin
      eff_period = PERIOD_CAP;
    end else begin
      eff_period = period_r;
    end
  end

  assign diff_gain = (in_item.price > last_price_r) ? in_item.price - last_price_r : '0;
  assign diff_loss = (in_item.price > last_price_r) ? '0 : last_price_r - in_item.price;
  assign count_inc = {1'b0, count_r} + (CNT_W+1)'(1);

  assign sel_avg = (state_r == S_LOAD_G) ? gain_avg_r : loss_avg_r;
  assign sel_x   = (state_r == S_LOAD_G) ? gain_r : loss_r;
  assign p_less  = p_r - PERIOD_W'(1);
  assign prod    = PROD_W'(sel_avg) * PROD_W'(p_less);
  assign num_avg = warm_end_r ? DIV_NUM_W'({sel_avg, {GUARD_BITS{1'b0}}})
                              : DIV_NUM_W'(prod)
                                + DIV_NUM_W'({sel_x, {GUARD_BITS{1'b0}}});

  assign gain_scaled = RSI_MUL_W'(gain_avg_r) * RSI_MUL_W'(RSI_SCALE);
  assign rsi_num     = {gain_scaled, {PRICE_FRAC_BITS{1'b0}}};

  always_comb begin
    state_nxt      = state_r;
    period_nxt     = cfg_we ? cfg_wdata : period_r;
    last_price_nxt = last_price_r;
    gain_avg_nxt   = gain_avg_r;
    loss_avg_nxt   = loss_avg_r;
    count_nxt      = count_r;
    have_prev_nxt  = have_prev_r;
    gain_nxt       = gain_r;
    loss_nxt       = loss_r;
    p_nxt          = p_r;
    warm_end_nxt   = warm_end_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    div_start      = 1'b0;
    div_req        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_price_nxt = in_item.price;
          if (in_item.new_series || !have_prev_r) begin
            gain_avg_nxt  = '0;
            loss_avg_nxt  = '0;
            count_nxt     = '0;
            have_prev_nxt = 1'b1;
          end else begin
            gain_nxt = diff_gain;
            loss_nxt = diff_loss;
            p_nxt    = eff_period;
            if (count_r != SMOOTHING_MARK) begin
              gain_avg_nxt = gain_avg_r + AVG_W'(diff_gain);
              loss_avg_nxt = loss_avg_r + AVG_W'(diff_loss);
              if (count_inc < {1'b0, eff_period}) begin
                count_nxt = count_inc[CNT_W-1:0];
              end else begin
                count_nxt    = SMOOTHING_MARK;
                warm_end_nxt = 1'b1;
                state_nxt    = S_LOAD_G;
              end
            end else begin
              warm_end_nxt = 1'b0;
              state_nxt    = S_LOAD_G;
            end
          end
        end
      end
      S_LOAD_G, S_LOAD_L: begin
        div_start     = 1'b1;
        div_req.num   = num_avg;
        div_req.den   = DIV_DEN_W'(p_r);
        div_req.rem   = '0;
        div_req.steps = STEP_W'(DIV_NUM_W);
        state_nxt     = (state_r == S_LOAD_G) ? S_WAIT_G : S_WAIT_L;
      end
      S_WAIT_G: begin
        if (div_sts.done) begin
          gain_avg_nxt = div_q;
          state_nxt    = S_LOAD_L;
        end
      end
      S_WAIT_L: begin
        if (div_sts.done) begin
          loss_avg_nxt = div_q;
          state_nxt    = S_LOAD_R;
        end
      end
      S_LOAD_R: begin
        if (loss_avg_r == '0) begin
          res_nxt.rsi     = RSI_FULL;
          res_nxt.no_loss = 1'b1;
          state_nxt       = S_OUT;
        end else begin
          div_start     = 1'b1;
          div_req.num   = {rsi_num[RSI_W-1:0], {(DIV_NUM_W-RSI_W){1'b0}}};
          div_req.den   = DIV_DEN_W'(gain_avg_r) + DIV_DEN_W'(loss_avg_r);
          div_req.rem   = DIV_DEN_W'(rsi_num[RSI_NUM_W-1:RSI_W]);
          div_req.steps = STEP_W'(RSI_W);
          state_nxt     = S_WAIT_R;
        end
      end
      S_WAIT_R: begin
        if (div_sts.done) begin
          res_nxt.rsi     = div_q[RSI_W-1:0];
          res_nxt.no_loss = 1'b0;
          state_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_W'(PERIOD_RESET);
      count_r     <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      count_r     <= count_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_price_r <= last_price_nxt;
    gain_avg_r   <= gain_avg_nxt;
    loss_avg_r   <= loss_avg_nxt;
    gain_r       <= gain_nxt;
    loss_r       <= loss_nxt;
    p_r          <= p_nxt;
    warm_end_r   <= warm_end_nxt;
    res_r        <= res_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `RSI_ASSERT(a_done_in_wait, div_sts.done |-> (state_r == S_WAIT_G || state_r == S_WAIT_L || state_r == S_WAIT_R), "divider finished outside a wait state")
  `RSI_ASSERT(a_ready_div_idle, in_ready |-> !div_sts.busy, "item taken while divider busy")
  `RSI_ASSERT(a_no_loss_full, (out_valid && out_item.no_loss) |-> (out_item.rsi == RSI_FULL), "no-loss item without full-scale rsi")
  `RSI_ASSERT_NEXT(a_load_starts, state_r == S_LOAD_G, (state_r == S_WAIT_G) && div_sts.busy, "gain division not under way")

endmodule
